// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Define ASSERT_OFF to drop
// all checks from a build.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ----- hw/rtl/esc_pkg.sv -----
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants of the elevator sweep controller: item opcodes and the
// fixed widths of the item and result fields, and the capacity after reset.
// ----------------------------------------------------------------------------
package esc_pkg;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int FLOOR_W = 5;
    localparam int CAP_W   = 4;
    localparam int WAIT_W  = 8;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    // Item opcodes
    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_CALL = 2'd1;
    localparam logic [OP_W-1:0] OP_DEST = 2'd2;

endpackage

// ----- hw/rtl/esc_ram.sv -----
// ----------------------------------------------------------------------------
// esc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module esc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 17
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/elevator_sweep_controller.sv -----
// ----------------------------------------------------------------------------
// elevator_sweep_controller
// Single-car LOOK scheduler; per-floor pickup/drop-off counters in one RAM.
// Calls, destinations and parked ticks finish in S_UPD or S_LOAD; a moving tick
// goes on through the one-read-per-cycle scan in S_SCAN, then S_LAST and S_MOVE.
// Throughput: one item at a time, busy high meanwhile; next accept at the
// edge ending the done cycle.
// Reset: valid flops clear (counters read as zero), car at floor 0 heading
// up, no riders, nobody waiting, capacity 8; no clear pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module elevator_sweep_controller
    import esc_pkg::*;
#(
    parameter int TOP_FLOOR   = 16,
    parameter int COUNT_WIDTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    // Item channel
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    op,
    input  logic [FLOOR_W-1:0] floor,
    // Capacity register
    input  logic               cfg_we,
    input  logic [CAP_W-1:0]   cfg_wdata,
    // Result channel
    output logic               done,
    output logic [FLOOR_W-1:0] car_floor,
    output logic               heading_up,
    output logic [CAP_W-1:0]   riders,
    output logic [WAIT_W-1:0]  waiting,
    output logic [CAP_W-1:0]   boarded,
    output logic [CAP_W-1:0]   alighted,
    output logic               idle
);

    localparam int NFLOORS = TOP_FLOOR + 1;
    localparam int POS_W   = $clog2(NFLOORS);
    localparam int CNT_W   = COUNT_WIDTH;
    localparam int ENT_W   = 2 * CNT_W;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [POS_W-1:0] POS_TOP = POS_W'(TOP_FLOOR);
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_LOAD,
        S_SCAN,
        S_LAST,
        S_MOVE
    } state_t;

    // State and registers
    state_t             state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               sweep_reg, sweep_next;
    logic [CAP_W-1:0]   inside_reg, inside_next;
    logic [CNT_W-1:0]   outside_reg, outside_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [NFLOORS-1:0] valid_reg, valid_next;
    logic               done_reg, done_next;
    logic [CAP_W-1:0]   boarded_reg, boarded_next;
    logic [CAP_W-1:0]   alighted_reg, alighted_next;
    logic               idle_reg, idle_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic               fok_reg, fok_next;
    logic [POS_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               scan_vld_reg, scan_vld_next;
    logic [POS_W-1:0]   hi_reg, hi_next;
    logic [POS_W-1:0]   lo_reg, lo_next;
    logic [POS_W-1:0]   rd_addr_reg;

    // RAM port
    logic               ram_we;
    logic [POS_W-1:0]   ram_waddr;
    logic [ENT_W-1:0]   ram_wdata;
    logic [POS_W-1:0]   ram_raddr;
    logic [ENT_W-1:0]   ram_rdata;

    // Counter RAM: entry = {pickup, dropoff}
    esc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NFLOORS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Read data, never-written floors read as zero
    logic [CNT_W-1:0] ent_pk, ent_dr;
    assign {ent_pk, ent_dr} = valid_reg[rd_addr_reg] ? ram_rdata : '0;

    // Floor range check on the incoming item
    logic flr_ok;
    assign flr_ok = (6'(floor) <= 6'(TOP_FLOOR));

    // Saturating increments for call/destination
    logic [CNT_W-1:0] pk_inc, dr_inc, out_inc;
    assign pk_inc  = (ent_pk == CNT_MAX) ? CNT_MAX : ent_pk + 1'b1;
    assign dr_inc  = (ent_dr == CNT_MAX) ? CNT_MAX : ent_dr + 1'b1;
    assign out_inc = (outside_reg == CNT_MAX) ? CNT_MAX : outside_reg + 1'b1;

    // Unload then load at the car floor
    logic [CAP_W-1:0] alight, in1, room, board, in2;
    logic [CNT_W-1:0] out1, pk1, dr1;
    assign alight = (ent_dr >= CNT_W'(inside_reg)) ? inside_reg : ent_dr[CAP_W-1:0];
    assign in1    = inside_reg - alight;
    assign room   = (cap_reg > in1) ? cap_reg - in1 : '0;
    assign board  = (ent_pk >= CNT_W'(room)) ? room : ent_pk[CAP_W-1:0];
    assign in2    = in1 + board;
    assign out1   = (outside_reg >= CNT_W'(board)) ? outside_reg - CNT_W'(board) : '0;
    assign pk1    = ent_pk - CNT_W'(board);
    assign dr1    = ent_dr - CNT_W'(alight);

    // Scan bound update, one floor per cycle
    logic             req;
    logic [POS_W-1:0] scan_hi, scan_lo;
    assign req     = (|ent_pk) || (|ent_dr);
    assign scan_hi = (scan_vld_reg && req && (rd_addr_reg > hi_reg)) ? rd_addr_reg : hi_reg;
    assign scan_lo = (scan_vld_reg && req && (rd_addr_reg < lo_reg)) ? rd_addr_reg : lo_reg;

    // One-floor move with reversal at the sweep ends
    logic [POS_W-1:0] mv_pos;
    logic             mv_up;
    always_comb
    begin
        mv_pos = pos_reg;
        mv_up  = sweep_reg;
        if (mv_up)
        begin
            if ((mv_pos < hi_reg) || (mv_pos < lo_reg))
                mv_pos = mv_pos + 1'b1;
            else
                mv_up = 1'b0;
        end
        if (!mv_up)
        begin
            if ((mv_pos > lo_reg) || (mv_pos > hi_reg))
                mv_pos = mv_pos - 1'b1;
            else
                mv_up = 1'b1;
        end
    end

    // Sequencer next-state logic
    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        sweep_next    = sweep_reg;
        inside_next   = inside_reg;
        outside_next  = outside_reg;
        valid_next    = valid_reg;
        done_next     = 1'b0;
        boarded_next  = boarded_reg;
        alighted_next = alighted_reg;
        idle_next     = idle_reg;
        op_next       = op_reg;
        fok_next      = fok_reg;
        scan_idx_next = scan_idx_reg;
        scan_vld_next = 1'b0;
        hi_next       = scan_hi;
        lo_next       = scan_lo;
        ram_we        = 1'b0;
        ram_waddr     = rd_addr_reg;
        ram_wdata     = {ent_pk, ent_dr};
        ram_raddr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = op;
                    fok_next = flr_ok;
                    if (op == OP_TICK)
                    begin
                        ram_raddr  = pos_reg;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        ram_raddr  = flr_ok ? POS_W'(floor) : '0;
                        state_next = S_UPD;
                    end
                end
            end

            S_UPD:
            begin
                case (op_reg)
                    OP_CALL:
                    begin
                        if (fok_reg)
                        begin
                            ram_we       = 1'b1;
                            ram_wdata    = {pk_inc, ent_dr};
                            outside_next = out_inc;
                        end
                    end
                    OP_DEST:
                    begin
                        if (fok_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {ent_pk, dr_inc};
                        end
                    end
                    default:
                    begin
                    end
                endcase
                boarded_next  = '0;
                alighted_next = '0;
                idle_next     = 1'b0;
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end

            S_LOAD:
            begin
                ram_we        = 1'b1;
                ram_wdata     = {pk1, dr1};
                inside_next   = in2;
                outside_next  = out1;
                boarded_next  = board;
                alighted_next = alight;
                if ((out1 == '0) && (in2 == '0))
                begin
                    idle_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idle_next     = 1'b0;
                    hi_next       = POS_ONE;
                    lo_next       = POS_ONE;
                    scan_idx_next = '0;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                ram_raddr     = scan_idx_reg;
                scan_vld_next = 1'b1;
                if (scan_idx_reg == POS_TOP)
                    state_next = S_LAST;
                else
                    scan_idx_next = scan_idx_reg + 1'b1;
            end

            S_LAST:
            begin
                state_next = S_MOVE;
            end

            S_MOVE:
            begin
                pos_next   = mv_pos;
                sweep_next = mv_up;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ram_we)
            valid_next[ram_waddr] = 1'b1;
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pos_reg      <= '0;
            sweep_reg    <= 1'b1;
            inside_reg   <= '0;
            outside_reg  <= '0;
            cap_reg      <= CAP_RESET;
            valid_reg    <= '0;
            done_reg     <= 1'b0;
            scan_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            sweep_reg    <= sweep_next;
            inside_reg   <= inside_next;
            outside_reg  <= outside_next;
            valid_reg    <= valid_next;
            done_reg     <= done_next;
            scan_vld_reg <= scan_vld_next;
            if (cfg_we)
                cap_reg <= cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        boarded_reg  <= boarded_next;
        alighted_reg <= alighted_next;
        idle_reg     <= idle_next;
        op_reg       <= op_next;
        fok_reg      <= fok_next;
        scan_idx_reg <= scan_idx_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        rd_addr_reg  <= ram_raddr;
    end

    // Waiting count, held at the top of the 8-bit field
    generate
        if (CNT_W > WAIT_W)
        begin : g_wait_sat
            assign waiting = (outside_reg > CNT_W'(255)) ? '1 : outside_reg[WAIT_W-1:0];
        end
        else
        begin : g_wait_ext
            assign waiting = WAIT_W'(outside_reg);
        end
    endgenerate

    // Outputs
    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign car_floor  = FLOOR_W'(pos_reg);
    assign heading_up = sweep_reg;
    assign riders     = inside_reg;
    assign boarded    = boarded_reg;
    assign alighted   = alighted_reg;
    assign idle       = idle_reg;

    // Checks
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMPL(a_done_free, clk, rst_n, done, !busy)
    `ASSERT_IMPL(a_idle_noboard, clk, rst_n, done && idle, boarded == '0)

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the elevator sweep controller. A queue-fed driver
// issues call, destination and tick items under random sender gaps. A
// clocked monitor keeps its own model of the car, the floor counters and the
// capacity. It predicts every result at item accept and compares the done
// strobes against it field by field. The run has a directed opening, several
// random phases at different capacities, and a flood that saturates the
// counters.
// ----------------------------------------------------------------------------
module tb_top;
    import esc_pkg::*;

    localparam int TOP_FLOOR   = 16;
    localparam int COUNT_MAX   = 255;
    localparam int TICK_CYCLES = TOP_FLOOR + 4;
    localparam int CYCLE_LIMIT = 300000;

    // Opcode the block does not decode
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FLOOR_W-1:0] floor;
    } floor_req_t;

    typedef struct packed {
        logic [FLOOR_W-1:0] car_floor;
        logic               heading_up;
        logic [CAP_W-1:0]   riders;
        logic [WAIT_W-1:0]  waiting;
        logic [CAP_W-1:0]   boarded;
        logic [CAP_W-1:0]   alighted;
        logic               idle;
    } car_report_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic [OP_W-1:0]    op        = OP_TICK;
    logic [FLOOR_W-1:0] floor     = '0;
    logic               cfg_we    = 1'b0;
    logic [CAP_W-1:0]   cfg_wdata = '0;
    logic               busy;
    logic               done;
    logic [FLOOR_W-1:0] car_floor;
    logic               heading_up;
    logic [CAP_W-1:0]   riders;
    logic [WAIT_W-1:0]  waiting;
    logic [CAP_W-1:0]   boarded;
    logic [CAP_W-1:0]   alighted;
    logic               idle;

    floor_req_t  req_q[$];
    car_report_t report_q[$];
    car_report_t next_report;
    int          n_issued    = 0;
    int          n_accepted  = 0;
    int          n_errors    = 0;
    int          gap_pct     = 0;
    int          cycle_count = 0;

    // Car model, reset state
    int pickups [TOP_FLOOR+1] = '{default: 0};
    int dropoffs[TOP_FLOOR+1] = '{default: 0};
    int car_pos    = 0;
    int sweep_up   = 1;
    int in_car     = 0;
    int hall_queue = 0;
    int car_cap    = int'(CAP_RESET);

    elevator_sweep_controller i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .floor      (floor),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .car_floor  (car_floor),
        .heading_up (heading_up),
        .riders     (riders),
        .waiting    (waiting),
        .boarded    (boarded),
        .alighted   (alighted),
        .idle       (idle)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    function automatic int sat_inc(int v);
        return (v >= COUNT_MAX) ? COUNT_MAX : v + 1;
    endfunction

    // One controller step: unload, load, then, unless parked, scan and move one floor
    task automatic run_tick(output int n_on, output int n_off, output int parked);
        int pos;
        int hi;
        int lo;
        pos    = car_pos;
        hi     = 1;
        lo     = 1;
        n_on   = 0;
        n_off  = 0;
        parked = 0;
        while (dropoffs[pos] > 0 && in_car > 0)
        begin
            dropoffs[pos] -= 1;
            in_car        -= 1;
            n_off         += 1;
        end
        while (pickups[pos] > 0 && in_car < car_cap)
        begin
            pickups[pos] -= 1;
            in_car       += 1;
            if (hall_queue > 0)
                hall_queue -= 1;
            n_on += 1;
        end
        if (hall_queue == 0 && in_car == 0)
        begin
            parked = 1;
            return;
        end
        for (int f = 0; f <= TOP_FLOOR; f++)
        begin
            if (pickups[f] > 0 || dropoffs[f] > 0)
            begin
                if (f > hi) hi = f;
                if (f < lo) lo = f;
            end
        end
        if (sweep_up != 0)
        begin
            if (pos < hi || pos < lo)
                pos += 1;
            else
                sweep_up = 0;
        end
        if (sweep_up == 0)
        begin
            if (pos > lo || pos > hi)
                pos -= 1;
            else
                sweep_up = 1;
        end
        car_pos = pos;
    endtask

    // Apply one item to the model and build the report it should produce
    task automatic predict_report(input floor_req_t req, output car_report_t rep);
        int n_on;
        int n_off;
        int parked;
        n_on   = 0;
        n_off  = 0;
        parked = 0;
        case (req.op)
            OP_TICK:
                run_tick(n_on, n_off, parked);
            OP_CALL:
                if (req.floor <= TOP_FLOOR)
                begin
                    pickups[req.floor] = sat_inc(pickups[req.floor]);
                    hall_queue         = sat_inc(hall_queue);
                end
            OP_DEST:
                if (req.floor <= TOP_FLOOR)
                    dropoffs[req.floor] = sat_inc(dropoffs[req.floor]);
            default:
                ;
        endcase
        rep.car_floor  = FLOOR_W'(car_pos);
        rep.heading_up = sweep_up[0];
        rep.riders     = CAP_W'(in_car);
        rep.waiting    = WAIT_W'((hall_queue > 255) ? 255 : hall_queue);
        rep.boarded    = CAP_W'(n_on);
        rep.alighted   = CAP_W'(n_off);
        rep.idle       = parked[0];
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            n_errors++;
        end
    endfunction

    // Driver: next item goes out once the current one is taken
    always @(posedge clk)
    begin
        if (rst_n && (!start || !busy))
        begin
            if (req_q.size() > 0 && $urandom_range(99) >= gap_pct)
            begin
                start <= 1'b1;
                op    <= req_q[0].op;
                floor <= req_q[0].floor;
                void'(req_q.pop_front());
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check reports, track capacity writes, predict on accept
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (report_q.size() == 0)
                begin
                    $error("report with no item outstanding");
                    n_errors++;
                end
                else
                begin
                    check_field("car_floor",  int'(report_q[0].car_floor),
                                int'(car_floor));
                    check_field("heading_up", int'(report_q[0].heading_up),
                                int'(heading_up));
                    check_field("riders",     int'(report_q[0].riders),
                                int'(riders));
                    check_field("waiting",    int'(report_q[0].waiting),
                                int'(waiting));
                    check_field("boarded",    int'(report_q[0].boarded),
                                int'(boarded));
                    check_field("alighted",   int'(report_q[0].alighted),
                                int'(alighted));
                    check_field("idle",       int'(report_q[0].idle),
                                int'(idle));
                    void'(report_q.pop_front());
                end
            end
            if (cfg_we)
                car_cap = int'(cfg_wdata);
            if (start && !busy)
            begin
                predict_report('{op: op, floor: floor}, next_report);
                report_q.push_back(next_report);
                n_accepted++;
            end
        end
    end

    task automatic add_item(input logic [OP_W-1:0] code, input int fl);
        req_q.push_back('{op: code, floor: fl[FLOOR_W-1:0]});
        n_issued++;
    endtask

    // Mostly well-formed traffic, some out-of-range and undecoded items
    task automatic add_random_item();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            add_item(OP_TICK, $urandom_range(31));
        else if (r < 68)
            add_item(OP_CALL, $urandom_range(TOP_FLOOR));
        else if (r < 90)
            add_item(OP_DEST, $urandom_range(TOP_FLOOR));
        else if (r < 96)
            add_item(($urandom_range(1) != 0) ? OP_CALL : OP_DEST,
                     $urandom_range(31, TOP_FLOOR + 1));
        else
            add_item(OP_UNUSED, $urandom_range(31));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (n_accepted != n_issued || report_q.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_capacity(input int v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[CAP_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_random_phase(input int cap, input int pct, input int n);
        write_capacity(cap);
        @(negedge clk);
        gap_pct = pct;
        for (int i = 0; i < n; i++)
            add_random_item();
        wait_drained();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening at reset capacity
        add_item(OP_TICK, 0);        // empty car stays parked
        add_item(OP_CALL, 31);       // out of range, dropped
        add_item(OP_DEST, TOP_FLOOR + 1);
        add_item(OP_UNUSED, 5);      // undecoded op
        add_item(OP_DEST, 0);
        add_item(OP_TICK, 31);       // drop-off with empty car stays pending
        add_item(OP_CALL, 0);
        add_item(OP_CALL, TOP_FLOOR);
        add_item(OP_CALL, TOP_FLOOR);
        add_item(OP_DEST, TOP_FLOOR);
        add_item(OP_TICK, 0);        // boards at floor 0, starts upward
        add_item(OP_TICK, 0);
        add_item(OP_DEST, 1);
        add_item(OP_CALL, 1);
        add_item(OP_TICK, 0);
        add_item(OP_TICK, 0);
        add_item(OP_TICK, 0);
        add_item(OP_CALL, 0);
        add_item(OP_TICK, 0);
        add_item(OP_TICK, 0);
        add_item(OP_TICK, 0);
        add_item(OP_TICK, 0);
        wait_drained();

        run_random_phase(1,  0,  90);
        run_random_phase(15, 64, 90);
        run_random_phase(0,  6,  60);
        run_random_phase(8,  64, 90);
        run_random_phase(3,  0,  120);

        // Flood: saturate pickups, drop-offs and the waiting count at the top,
        // then drain with full loads until waiting runs out before pickups
        write_capacity(15);
        @(negedge clk);
        gap_pct = 0;
        for (int i = 0; i < 260; i++)
            add_item(OP_CALL, TOP_FLOOR);
        for (int i = 0; i < 10; i++)
            add_item(OP_CALL, TOP_FLOOR - 1);
        for (int i = 0; i < 260; i++)
            add_item(OP_DEST, TOP_FLOOR);
        for (int i = 0; i < 50; i++)
            add_item(OP_TICK, 0);
        wait_drained();

        // Let any stray strobe show up before judging
        repeat (TICK_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
